/* hdl/signed_int64_to_decimal_ascii_assert.svh */
// assertion macros for the decimal ascii converter
`ifndef SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define S64DA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define S64DA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define S64DA_ASSERT_NOW(label, ante, cons)
`define S64DA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/s64da_pkg.sv */
package s64da_pkg;
   localparam int ValueBits     = 64;
   localparam int NumDigits     = 20;
   localparam int BcdBits       = NumDigits * 4;
   localparam int StepsPerStage = 8;
   localparam int NumStages     = ValueBits / StepsPerStage;
   localparam int IdxBits       = $clog2(NumDigits);
   localparam int CharBits      = 6;
   localparam logic [CharBits-1:0] CharZero  = 6'd48;
   localparam logic [CharBits-1:0] CharMinus = 6'd45;

   typedef struct packed {
      logic                 neg;
      logic [BcdBits-1:0]   bcd;
      logic [ValueBits-1:0] bin;
   } dabble_type;
endpackage

/* hdl/s64da_dabble_stage.sv */
module s64da_dabble_stage import s64da_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  dabble_type in_data,
   output logic       in_ready,
   output logic       out_valid,
   output dabble_type out_data,
   input  logic       out_ready
);
   function automatic dabble_type dabble_steps(dabble_type d);
      dabble_type r;
      r = d;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int n = 0; n < NumDigits; n++) begin
            if (r.bcd[n*4 +: 4] >= 4'd5) begin
               r.bcd[n*4 +: 4] = r.bcd[n*4 +: 4] + 4'd3;
            end
         end
         {r.bcd, r.bin} = {r.bcd[BcdBits-2:0], r.bin, 1'b0};
      end
      return r;
   endfunction

   logic       valid_ff, valid_in;
   dabble_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= dabble_steps(in_data);
      end
   end
endmodule

/* hdl/s64da_serializer.sv */
module s64da_serializer import s64da_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  dabble_type          in_data,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CharBits-1:0] rsp_text_char,
   output logic                rsp_last_char
);
`include "signed_int64_to_decimal_ascii_assert.svh"

   function automatic logic [IdxBits-1:0] lead_digit(logic [BcdBits-1:0] bcd);
      logic [IdxBits-1:0] r;
      r = '0;
      for (int n = 0; n < NumDigits; n++) begin
         if (bcd[n*4 +: 4] != 4'd0) begin
            r = IdxBits'(n);
         end
      end
      return r;
   endfunction

   logic                busy_ff, busy_in;
   logic                minus_ff, minus_in;
   logic [IdxBits-1:0]  idx_ff, idx_in;
   logic [BcdBits-1:0]  bcd_ff;
   logic                xfer, load;

   assign xfer          = busy_ff && !rsp_stall;
   assign rsp_valid     = busy_ff;
   assign rsp_last_char = !minus_ff && (idx_ff == '0);
   assign rsp_text_char = minus_ff ? CharMinus
                        : CharZero + CharBits'(bcd_ff[idx_ff*4 +: 4]);
   assign in_ready      = !busy_ff || (xfer && rsp_last_char);
   assign load          = in_ready && in_valid;

   always_comb begin
      busy_in  = busy_ff;
      minus_in = minus_ff;
      idx_in   = idx_ff;
      if (xfer) begin
         if (minus_ff) begin
            minus_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         minus_in = in_data.neg;
         idx_in   = lead_digit(in_data.bcd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         minus_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         minus_ff <= minus_in;
         idx_ff   <= idx_in;
      end
      if (load) begin
         bcd_ff <= in_data.bcd;
      end
   end

   `S64DA_ASSERT_NOW(idx_in_range, busy_ff, idx_ff < IdxBits'(NumDigits))
   `S64DA_ASSERT_NOW(minus_not_last, busy_ff && minus_ff, !rsp_last_char)
   `S64DA_ASSERT_NEXT(idle_after_last, xfer && rsp_last_char && !in_valid, !busy_ff)
endmodule

/* hdl/signed_int64_to_decimal_ascii.sv */
// channel   ports                                   direction
// request   req_valid req_stall req_value           in
// response  rsp_valid rsp_stall rsp_text_char       out
//           rsp_last_char
// one value leaves as 1 to 20 characters, one per cycle without stall
// a value passes a negate register, 8 double-dabble stages and the serializer
// register, in that order, before its first character transfers
// the character serializer bounds the flow: it loads a new value as the last
// character of the one before transfers; stages fill behind a busy serializer
// reset clears all valid bits; stall holds every stage, nothing is lost
module signed_int64_to_decimal_ascii import s64da_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ValueBits-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CharBits-1:0]  rsp_text_char,
   output logic                 rsp_last_char
);
   logic       neg_valid_ff, neg_valid_in, neg_ready;
   dabble_type neg_ff;
   logic       stg_valid [0:NumStages];
   dabble_type stg_data  [0:NumStages];
   logic       stg_ready [0:NumStages];

   assign neg_ready    = !neg_valid_ff || stg_ready[0];
   assign req_stall    = !neg_ready;
   assign neg_valid_in = neg_ready ? req_valid : neg_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_valid_ff <= 1'b0;
      end else begin
         neg_valid_ff <= neg_valid_in;
      end
      if (neg_ready && req_valid) begin
         neg_ff.neg <= req_value[ValueBits-1];
         neg_ff.bcd <= '0;
         neg_ff.bin <= req_value[ValueBits-1] ? ('0 - req_value) : req_value;
      end
   end

   assign stg_valid[0] = neg_valid_ff;
   assign stg_data[0]  = neg_ff;

   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      s64da_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_data   (stg_data[i]),
         .in_ready  (stg_ready[i]),
         .out_valid (stg_valid[i+1]),
         .out_data  (stg_data[i+1]),
         .out_ready (stg_ready[i+1])
      );
   end

   s64da_serializer u_serial (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stg_valid[NumStages]),
      .in_data       (stg_data[NumStages]),
      .in_ready      (stg_ready[NumStages]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );
endmodule

/* tb/signed_int64_to_decimal_ascii_test.sv */
module signed_int64_to_decimal_ascii_test;
   import s64da_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ValueBits-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CharBits-1:0]  rsp_text_char;
   logic                 rsp_last_char;

   typedef struct packed {
      logic [CharBits-1:0] text_char;
      logic                last_char;
   } char_item_type;

   char_item_type pending_chars[$];
   int            mismatch_count = 0;
   int            values_sent = 0;
   int            chars_seen = 0;
   bit            quiet_phase = 1'b0;

   signed_int64_to_decimal_ascii dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_text_char(rsp_text_char), .rsp_last_char(rsp_last_char)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // decimal text of a value, most significant character first
   task automatic predict_text(input logic [ValueBits-1:0] v);
      logic [ValueBits-1:0] mag;
      logic [3:0]           digits[NumDigits];
      int                   n;
      char_item_type        c;
      n = 0;
      mag = v[ValueBits-1] ? (64'd0 - v) : v;
      do begin
         digits[n] = 4'(mag % 64'd10);
         mag = mag / 64'd10;
         n++;
      end while (mag != 0 && n < NumDigits);
      if (v[ValueBits-1]) begin
         c.text_char = CharMinus;
         c.last_char = 1'b0;
         pending_chars.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
         c.text_char = CharZero + CharBits'(digits[i]);
         c.last_char = (i == 0);
         pending_chars.push_back(c);
      end
   endtask

   task automatic send_value(input logic [ValueBits-1:0] v);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_text(v);
      values_sent++;
   endtask

   function automatic logic [ValueBits-1:0] rand_value();
      logic [ValueBits-1:0] v;
      int                   sh;
      v = {$urandom, $urandom};
      sh = $urandom_range(0, 63);
      case ($urandom_range(0, 2))
         0: v = v >> sh;
         1: v = 64'd0 - (v >> sh);
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_seen++;
         if (pending_chars.size() == 0)
            report_mismatch("character with nothing expected");
         else begin
            if (rsp_text_char !== pending_chars[0].text_char ||
                rsp_last_char !== pending_chars[0].last_char)
               report_mismatch($sformatf("got char %0d last %0d, want char %0d last %0d",
                  rsp_text_char, rsp_last_char,
                  pending_chars[0].text_char, pending_chars[0].last_char));
            void'(pending_chars.pop_front());
         end
      end
   end

   // random stall bursts on the result side
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 6)) @(posedge clock);
      end
   end

   task automatic test_extremes();
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h8000_0000_0000_0001);
      send_value(64'd9);
      send_value(64'd10);
      send_value(-64'sd10);
      send_value(64'd999_999_999_999_999_999);
      send_value(64'd1_000_000_000_000_000_000);
      send_value(64'hAAAA_AAAA_AAAA_AAAA);
      send_value(64'h5555_5555_5555_5555);
   endtask

   task automatic test_powers_of_ten();
      logic [ValueBits-1:0] p;
      p = 64'd1;
      for (int i = 0; i < 6; i++) begin
         send_value(p * 64'd1000 - 64'd1);
         send_value(64'd0 - p * 64'd1000);
         p = p * 64'd1000;
      end
   endtask

   task automatic test_random_values();
      for (int i = 0; i < 450; i++) begin
         if (i == 380) quiet_phase = 1'b1;
         send_value(rand_value());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_powers_of_ten();
      test_random_values();
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d values (extremes, sign edges, powers of ten, random)", values_sent);
      $display("checked %0d characters with random idle and stall bursts", chars_seen);
      if (mismatch_count == 0 && pending_chars.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/s64da_pkg.sv
hdl/s64da_dabble_stage.sv
hdl/s64da_serializer.sv
hdl/signed_int64_to_decimal_ascii.sv
tb/signed_int64_to_decimal_ascii_test.sv
